// ===== rtl/teit_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle edge intersection test package
// Shared widths, word types and helper functions.
// ----------------------------------------------------------------------------
package teit_pkg;

    localparam int COORD_BITS   = 20;
    localparam int NODE_ID_BITS = 20;
    localparam int WORD_BITS    = 60;
    // Differences of two coordinates.
    localparam int DIFF_BITS    = COORD_BITS + 1;
    // Cross product of two differences.
    localparam int CROSS_BITS   = 2 * DIFF_BITS + 1;
    // Product of a difference and a cross component.
    localparam int PROD_BITS    = DIFF_BITS + CROSS_BITS;
    // Sum of three such products.
    localparam int DOT_BITS     = PROD_BITS + 2;

    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [CROSS_BITS-1:0] t_cross;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [DOT_BITS-1:0]   t_dot;

    typedef struct packed {
        logic [WORD_BITS-1:0] first_node_ids;
        logic [WORD_BITS-1:0] second_node_ids;
        logic [WORD_BITS-1:0] first_corner_a;
        logic [WORD_BITS-1:0] first_corner_b;
        logic [WORD_BITS-1:0] first_corner_c;
        logic [WORD_BITS-1:0] second_corner_a;
        logic [WORD_BITS-1:0] second_corner_b;
        logic [WORD_BITS-1:0] second_corner_c;
    } t_in_word;

    typedef struct packed {
        logic faces_intersect;
        logic faces_share_node;
    } t_out_word;

    function automatic t_diff coord_of(input logic [WORD_BITS-1:0] w, input int k);
        logic signed [COORD_BITS-1:0] c;
        c = w[k*COORD_BITS +: COORD_BITS];
        return t_diff'(c);
    endfunction

    // The operands are widened first so that each product keeps all its bits.
    function automatic t_cross cross_comp(input t_diff a1, input t_diff b2,
                                          input t_diff a2, input t_diff b1);
        return t_cross'(a1) * t_cross'(b2) - t_cross'(a2) * t_cross'(b1);
    endfunction

endpackage

// ===== rtl/teit_edge.sv =====
// ----------------------------------------------------------------------------
// Edge test stages
// Per-edge sign evaluation of one first-triangle edge against the second
// triangle, given the registered normal and edge cross products.
// ----------------------------------------------------------------------------
module teit_edge (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  teit_pkg::t_diff      i_t [3],
    input  teit_pkg::t_diff      i_d [3],
    input  teit_pkg::t_diff      i_w [3],
    input  teit_pkg::t_cross     i_n [3],
    input  teit_pkg::t_cross     i_c [3][3],
    input  teit_pkg::t_diff      i_s [3][3],
    output logic                 o_cross
);
    import teit_pkg::*;

    // Stage A: products.
    t_prod r_pt [3], r_pd [3], r_pw [3];
    t_prod r_ps [3][3];
    logic  r_nz;
    // Stage B: dot sums and decision.
    t_dot  n_sd, n_sa, n_sb;
    t_dot  n_sk [3];
    logic  n_ok;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nz <= (i_n[0] != '0) || (i_n[1] != '0) || (i_n[2] != '0);
            for (int i = 0; i < 3; i++) begin
                r_pt[i] <= t_prod'(i_n[i]) * t_prod'(i_t[i]);
                r_pd[i] <= t_prod'(i_n[i]) * t_prod'(i_d[i]);
                r_pw[i] <= t_prod'(i_n[i]) * t_prod'(i_w[i]);
                for (int k = 0; k < 3; k++) begin
                    r_ps[k][i] <= t_prod'(i_s[k][i]) * t_prod'(i_c[k][i]);
                end
            end
        end
    end

    always_comb begin
        n_sd = t_dot'(r_pt[0]) + t_dot'(r_pt[1]) + t_dot'(r_pt[2]);
        n_sa = t_dot'(r_pd[0]) + t_dot'(r_pd[1]) + t_dot'(r_pd[2]);
        n_sb = t_dot'(r_pw[0]) + t_dot'(r_pw[1]) + t_dot'(r_pw[2]);
        for (int k = 0; k < 3; k++) begin
            n_sk[k] = t_dot'(r_ps[k][0]) + t_dot'(r_ps[k][1]) + t_dot'(r_ps[k][2]);
        end
        n_ok = r_nz && (n_sd != '0);
        if (n_sd > 0) begin
            if (n_sa > 0 || n_sb < 0) n_ok = 1'b0;
            for (int k = 0; k < 3; k++) if (n_sk[k] > 0) n_ok = 1'b0;
        end else begin
            if (n_sa < 0 || n_sb > 0) n_ok = 1'b0;
            for (int k = 0; k < 3; k++) if (n_sk[k] < 0) n_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cross <= n_ok;
        end
    end

endmodule

// ===== rtl/triangle_edge_intersection_test_core.sv =====
// ----------------------------------------------------------------------------
// Triangle edge intersection test core
// Tests each edge of one triangle against a second triangle.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+----------------------------
//  input   | in        | i_valid / o_ready    | i_data (teit_pkg::t_in_word)
//  result  | out       | o_valid / i_ready    | o_data (teit_pkg::t_out_word)
//
// A word passes five register stages: unpack and differences, cross products,
// dot-product multipliers, dot sums and sign tests, then the combining stage.
// One word enters per cycle while the output stage is empty or its result is
// being taken.
// The whole pipeline advances together whenever the output stage is empty or
// being taken, so a stall freezes every stage and nothing is lost or repeated.
// Reset clears only the valid bits; payload registers are not reset.
module triangle_edge_intersection_test_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  teit_pkg::t_in_word    i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output teit_pkg::t_out_word   o_data
);
    import teit_pkg::*;

    localparam int DEPTH = 5;

    logic [DEPTH-1:0] r_vld;
    logic             w_adv;

    // The pipeline moves when the last stage is empty or being taken.
    assign w_adv   = !r_vld[DEPTH-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // Stage 1: unpack, node comparison and coordinate differences.
    t_diff r_t [3][3];   // edge direction per first-triangle edge
    t_diff r_d [3][3];   // p0 - second a, per edge
    t_diff r_w [3][3];   // p1 - second a, per edge
    t_diff r_e1 [3], r_e2 [3];
    t_diff r_s [3][3];   // second triangle sides
    t_diff r_b [3][3][3]; // per edge i, side k: p0 - v[k]
    logic  r_share1;

    always_ff @(posedge i_clk) begin
        t_diff p [3][3];
        t_diff v [3][3];
        logic  sh;
        if (w_adv) begin
            sh = 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (i_data.first_node_ids[i*NODE_ID_BITS +: NODE_ID_BITS] ==
                        i_data.second_node_ids[j*NODE_ID_BITS +: NODE_ID_BITS]) sh = 1'b1;
                end
            end
            for (int k = 0; k < 3; k++) begin
                p[0][k] = coord_of(i_data.first_corner_a, k);
                p[1][k] = coord_of(i_data.first_corner_b, k);
                p[2][k] = coord_of(i_data.first_corner_c, k);
                v[0][k] = coord_of(i_data.second_corner_a, k);
                v[1][k] = coord_of(i_data.second_corner_b, k);
                v[2][k] = coord_of(i_data.second_corner_c, k);
            end
            r_share1 <= sh;
            for (int c = 0; c < 3; c++) begin
                r_e1[c] <= v[1][c] - v[0][c];
                r_e2[c] <= v[2][c] - v[0][c];
            end
            for (int i = 0; i < 3; i++) begin
                for (int c = 0; c < 3; c++) begin
                    r_t[i][c] <= p[(i+1)%3][c] - p[i][c];
                    r_d[i][c] <= p[i][c] - v[0][c];
                    r_w[i][c] <= p[(i+1)%3][c] - v[0][c];
                    r_s[i][c] <= v[(i+1)%3][c] - v[i][c];
                    for (int k = 0; k < 3; k++) begin
                        r_b[i][k][c] <= p[i][c] - v[k][c];
                    end
                end
            end
        end
    end

    // Stage 2: normal and the t x base cross products.
    t_cross r_n [3];
    t_cross r_c [3][3][3];
    t_diff  r_t2 [3][3], r_d2 [3][3], r_w2 [3][3], r_s2 [3][3];
    logic   r_share2;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_share2 <= r_share1;
            r_n[0] <= cross_comp(r_e1[1], r_e2[2], r_e1[2], r_e2[1]);
            r_n[1] <= cross_comp(r_e1[2], r_e2[0], r_e1[0], r_e2[2]);
            r_n[2] <= cross_comp(r_e1[0], r_e2[1], r_e1[1], r_e2[0]);
            r_t2 <= r_t;
            r_d2 <= r_d;
            r_w2 <= r_w;
            r_s2 <= r_s;
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_c[i][k][0] <= cross_comp(r_t[i][1], r_b[i][k][2],
                                               r_t[i][2], r_b[i][k][1]);
                    r_c[i][k][1] <= cross_comp(r_t[i][2], r_b[i][k][0],
                                               r_t[i][0], r_b[i][k][2]);
                    r_c[i][k][2] <= cross_comp(r_t[i][0], r_b[i][k][1],
                                               r_t[i][1], r_b[i][k][0]);
                end
            end
        end
    end

    // Stages 3 and 4: one edge unit per first-triangle edge.
    logic w_cross [3];
    logic r_share3, r_share4;

    for (genvar g = 0; g < 3; g++) begin : g_edge
        teit_edge u_edge (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_t     (r_t2[g]),
            .i_d     (r_d2[g]),
            .i_w     (r_w2[g]),
            .i_n     (r_n),
            .i_c     (r_c[g]),
            .i_s     (r_s2),
            .o_cross (w_cross[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_share3 <= r_share2;
            r_share4 <= r_share3;
        end
    end

    // Stage 5: combine into the result word.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_data.faces_share_node <= r_share4;
            o_data.faces_intersect  <= (w_cross[0] | w_cross[1] | w_cross[2]) & ~r_share4;
        end
    end

endmodule

// ===== rtl/teit_checker.sv =====
// ----------------------------------------------------------------------------
// Triangle edge intersection test checker
// Port-level checks bound to the core.
// ----------------------------------------------------------------------------
module teit_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_ready,
    input  logic                 o_valid,
    input  logic                 i_ready,
    input  teit_pkg::t_out_word  o_data
);
    import teit_pkg::*;

    // A shared node never reports an intersection.
    a_share: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.faces_intersect && o_data.faces_share_node))
        else $error("intersect reported with shared node");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // The input side is ready whenever the output is not held.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("ready dropped without stall");

    // A word offered on the input stays offered until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid)
        else $error("input word withdrawn before acceptance");

endmodule

bind triangle_edge_intersection_test_core teit_checker u_teit_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// ===== sim/tb_triangle_edge_intersection_test_core.sv =====
// ----------------------------------------------------------------------------
// Triangle edge intersection test core testbench
// Drives triangle pairs through the valid/ready input channel, predicts the
// share and crossing flags with exact integer arithmetic and compares every
// result word in order. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_edge_intersection_test_core;
    import teit_pkg::*;

    // 21-bit differences, 43-bit cross terms and 66-bit dots all fit in 128 bits.
    typedef logic signed [127:0] t_wide;
    typedef t_wide t_wvec [3];

    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_data;
    logic      o_valid;
    logic      i_ready = 1'b1;
    t_out_word o_data;

    t_out_word expected_flags [$];
    int        error_count = 0;
    int        cycle_count = 0;
    bit        sink_stall_enable;

    triangle_edge_intersection_test_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor. Everything is done on wide signed integers, so every
    // product and sum is exact and only signs are ever inspected.
    // ------------------------------------------------------------------
    function automatic t_wvec point_of(input logic [WORD_BITS-1:0] w);
        t_wvec p;
        for (int k = 0; k < 3; k++) begin
            p[k] = t_wide'($signed(w[k*COORD_BITS +: COORD_BITS]));
        end
        return p;
    endfunction

    function automatic t_wvec minus(input t_wvec a, input t_wvec b);
        t_wvec r;
        for (int k = 0; k < 3; k++) r[k] = a[k] - b[k];
        return r;
    endfunction

    function automatic t_wvec cross3(input t_wvec a, input t_wvec b);
        t_wvec r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    function automatic int sign_of_dot(input t_wvec a, input t_wvec b);
        t_wide s;
        s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        return (s < 0) ? -1 : ((s == 0) ? 0 : 1);
    endfunction

    function automatic bit edge_pierces(input t_wvec p0, input t_wvec p1,
                                        input t_wvec v0, input t_wvec v1,
                                        input t_wvec v2);
        t_wvec nrm;
        t_wvec dir;
        t_wvec corner [3];
        int    sd;
        int    sa;
        int    sb;
        nrm = cross3(minus(v1, v0), minus(v2, v0));
        if (nrm[0] == 0 && nrm[1] == 0 && nrm[2] == 0) return 1'b0;
        dir = minus(p1, p0);
        sd  = sign_of_dot(nrm, dir);
        if (sd == 0) return 1'b0;
        sa = sign_of_dot(nrm, minus(p0, v0));
        sb = sign_of_dot(nrm, minus(p1, v0));
        // The crossing parameter lies in [0,1] once the sign of det is folded in.
        if (sd > 0 && (sa > 0 || sb < 0)) return 1'b0;
        if (sd < 0 && (sa < 0 || sb > 0)) return 1'b0;
        corner[0] = v0;
        corner[1] = v1;
        corner[2] = v2;
        for (int k = 0; k < 3; k++) begin
            if (sd * sign_of_dot(minus(corner[(k + 1) % 3], corner[k]),
                                 cross3(dir, minus(p0, corner[k]))) > 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_out_word predict_flags(input t_in_word w);
        t_out_word r;
        t_wvec     fp [3];
        bit        share;
        bit        hit;
        share = 1'b0;
        hit   = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (w.first_node_ids[i*NODE_ID_BITS +: NODE_ID_BITS] ==
                    w.second_node_ids[j*NODE_ID_BITS +: NODE_ID_BITS]) share = 1'b1;
            end
        end
        fp[0] = point_of(w.first_corner_a);
        fp[1] = point_of(w.first_corner_b);
        fp[2] = point_of(w.first_corner_c);
        for (int i = 0; i < 3; i++) begin
            if (edge_pierces(fp[i], fp[(i + 1) % 3], point_of(w.second_corner_a),
                             point_of(w.second_corner_b), point_of(w.second_corner_c)))
                hit = 1'b1;
        end
        r.faces_intersect  = hit && !share;
        r.faces_share_node = share;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [WORD_BITS-1:0] pack_point(input int x, input int y,
                                                       input int z);
        logic [WORD_BITS-1:0] w;
        w[0 +: COORD_BITS]            = x[COORD_BITS-1:0];
        w[COORD_BITS +: COORD_BITS]   = y[COORD_BITS-1:0];
        w[2*COORD_BITS +: COORD_BITS] = z[COORD_BITS-1:0];
        return w;
    endfunction

    function automatic logic [WORD_BITS-1:0] random_word();
        return WORD_BITS'({$urandom(), $urandom()});
    endfunction

    // Small coordinates make crossings frequent; a few draws use full range.
    function automatic logic [WORD_BITS-1:0] random_point(input int span);
        if (span == 0) return random_word();
        return pack_point($urandom_range(0, 2 * span) - span,
                          $urandom_range(0, 2 * span) - span,
                          $urandom_range(0, 2 * span) - span);
    endfunction

    function automatic logic [WORD_BITS-1:0] distinct_ids(input int base);
        logic [WORD_BITS-1:0] w;
        w = random_word();
        for (int k = 0; k < 3; k++) begin
            w[k*NODE_ID_BITS +: NODE_ID_BITS] = NODE_ID_BITS'(base + k);
        end
        return w;
    endfunction

    // Sends one word: optional random gap, then holds valid until accepted.
    task automatic send_word(input t_in_word w, input bit with_gap);
        int gap;
        gap = with_gap ? gap_length() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        expected_flags = {expected_flags, predict_flags(w)};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        go_idle();
        while (expected_flags.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------
    task automatic test_directed();
        t_in_word w;
        // A clean crossing: vertical edge through a flat triangle.
        w.first_node_ids  = distinct_ids(10);
        w.second_node_ids = distinct_ids(20);
        w.first_corner_a  = pack_point(1, 1, -5);
        w.first_corner_b  = pack_point(1, 1, 5);
        w.first_corner_c  = pack_point(50, 50, 5);
        w.second_corner_a = pack_point(0, 0, 0);
        w.second_corner_b = pack_point(10, 0, 0);
        w.second_corner_c = pack_point(0, 10, 0);
        send_word(w, 1'b0);
        // Same geometry but a shared node suppresses the crossing.
        w.second_node_ids[NODE_ID_BITS +: NODE_ID_BITS] = NODE_ID_BITS'(12);
        send_word(w, 1'b0);
        // Every pairing of node slots shares once.
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w.second_node_ids = distinct_ids(20);
                w.second_node_ids[j*NODE_ID_BITS +: NODE_ID_BITS] =
                    w.first_node_ids[i*NODE_ID_BITS +: NODE_ID_BITS];
                send_word(w, 1'b0);
            end
        end
        w.second_node_ids = distinct_ids(20);
        // Edge touches the plane at its start (lam 0) and at its end (lam 1).
        w.first_corner_a = pack_point(1, 1, 0);
        send_word(w, 1'b0);
        w.first_corner_a = pack_point(1, 1, -5);
        w.first_corner_b = pack_point(1, 1, 0);
        send_word(w, 1'b0);
        // Edge passes exactly through a side and through a corner.
        w.first_corner_a = pack_point(5, 0, -5);
        w.first_corner_b = pack_point(5, 0, 5);
        send_word(w, 1'b0);
        w.first_corner_a = pack_point(0, 0, -5);
        w.first_corner_b = pack_point(0, 0, 5);
        send_word(w, 1'b0);
        // Just outside the triangle.
        w.first_corner_a = pack_point(6, 6, -5);
        w.first_corner_b = pack_point(6, 6, 5);
        send_word(w, 1'b0);
        // Edge lying in the plane (det zero).
        w.first_corner_a = pack_point(1, 1, 0);
        w.first_corner_b = pack_point(2, 1, 0);
        send_word(w, 1'b0);
        // Collinear second triangle.
        w.first_corner_a  = pack_point(1, 1, -5);
        w.first_corner_b  = pack_point(1, 1, 5);
        w.second_corner_c = pack_point(20, 0, 0);
        send_word(w, 1'b0);
        // Extreme coordinates and a large triangle.
        w.second_corner_a = pack_point(-(1 << 19), -(1 << 19), 0);
        w.second_corner_b = pack_point((1 << 19) - 1, -(1 << 19), 0);
        w.second_corner_c = pack_point(-(1 << 19), (1 << 19) - 1, 0);
        w.first_corner_a  = pack_point(-(1 << 19), -(1 << 19), -(1 << 19));
        w.first_corner_b  = pack_point(-(1 << 19), -(1 << 19), (1 << 19) - 1);
        w.first_corner_c  = pack_point((1 << 19) - 1, (1 << 19) - 1, (1 << 19) - 1);
        send_word(w, 1'b0);
        w.first_node_ids  = '1;
        w.second_node_ids = '0;
        send_word(w, 1'b0);
        w.second_node_ids = '1;
        send_word(w, 1'b0);
        w = '0;
        send_word(w, 1'b0);
        w = '1;
        send_word(w, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_pairs(input int count);
        t_in_word w;
        int       span;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0:       span = 0;
                1:       span = 1 << 19;
                2, 3:    span = 4;
                default: span = 40;
            endcase
            w = {8{random_word()}};
            w.first_node_ids  = random_word();
            w.second_node_ids = random_word();
            // Mostly small ids, of which one or more may collide.
            if ($urandom_range(0, 3) != 0) begin
                w.first_node_ids  = distinct_ids(0);
                w.second_node_ids = distinct_ids(3);
                for (int k = 0; k < 3; k++) begin
                    w.first_node_ids[k*NODE_ID_BITS +: NODE_ID_BITS] =
                        NODE_ID_BITS'($urandom_range(0, 2) * 3 + k);
                end
            end
            w.first_corner_a  = random_point(span);
            w.first_corner_b  = random_point(span);
            w.first_corner_c  = random_point(span);
            w.second_corner_a = random_point(span);
            w.second_corner_b = random_point(span);
            w.second_corner_c = random_point(span);
            // Sometimes a flat second triangle in z = 0.
            if (span != 0 && $urandom_range(0, 1)) begin
                w.second_corner_a[2*COORD_BITS +: COORD_BITS] = '0;
                w.second_corner_b[2*COORD_BITS +: COORD_BITS] = '0;
                w.second_corner_c[2*COORD_BITS +: COORD_BITS] = '0;
            end
            // Random upper bits keep every input bit toggling.
            w.first_corner_a[WORD_BITS-1]  = $urandom_range(0, 1);
            w.second_corner_c[WORD_BITS-1] = $urandom_range(0, 1);
            send_word(w, n % 200 < 150);
            if (n == count / 2) wait_drained();
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Result sink: random back-pressure and in-order comparison.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || !sink_stall_enable) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) < 70);
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_flags.size() == 0) begin
                $error("result word with nothing expected: %b", o_data);
                error_count++;
            end else begin
                want = expected_flags.pop_front();
                if (o_data.faces_intersect !== want.faces_intersect) begin
                    $error("faces_intersect: expected %b, actual %b",
                           want.faces_intersect, o_data.faces_intersect);
                    error_count++;
                end
                if (o_data.faces_share_node !== want.faces_share_node) begin
                    $error("faces_share_node: expected %b, actual %b",
                           want.faces_share_node, o_data.faces_share_node);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("triangle_edge_intersection_test_core regression: fail");
            $finish;
        end
    end

    initial begin
        sink_stall_enable = 1'b0;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_data            = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        sink_stall_enable = 1'b1;
        test_random_pairs(1200);
        // Allow the pipeline to settle and catch any stray result words.
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_flags.size() == 0) begin
            $display("triangle_edge_intersection_test_core regression: pass");
        end else begin
            $display("triangle_edge_intersection_test_core regression: fail");
        end
        $finish;
    end

endmodule
